[hdl/idpci_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idpci_pkg
// Types, codes and constants shared by the ID-port isolation card logic.
// ----------------------------------------------------------------------------
package idpci_pkg;

  // Request function codes
  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_READ  = 2'd1,
    FN_RESET = 2'd2,
    FN_NONE  = 2'd3
  } func_e;

  // Card phase, one-hot
  typedef enum logic [2:0] {
    PH_WAIT   = 3'b001,
    PH_CMD    = 3'b010,
    PH_ACTIVE = 3'b100
  } phase_e;

  // Reported card_state codes
  localparam logic [1:0] CS_WAIT   = 2'd0;
  localparam logic [1:0] CS_CMD    = 2'd1;
  localparam logic [1:0] CS_ACTIVE = 2'd2;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MAC0     = 3'd0,
    CFG_MAC1     = 3'd1,
    CFG_MAC2     = 3'd2,
    CFG_MAKER    = 3'd3,
    CFG_ADDR_CFG = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Sequence generator
  localparam logic [7:0] SEQ_START = 8'hff;
  localparam logic [7:0] SEQ_POLY  = 8'hcf;
  localparam logic [7:0] SEQ_LEN   = 8'd255;

  // Command bytes and masks
  localparam logic [7:0] CMD_WAIT      = 8'h00;
  localparam logic [7:0] CMD_GLOBAL_RST = 8'hc0;
  localparam logic [7:0] CMD_LOAD_MASK = 8'hc0;
  localparam logic [7:0] CMD_LOAD      = 8'h80;
  localparam logic [7:0] CMD_TAG_MASK  = 8'hf8;
  localparam logic [7:0] CMD_SET_TAG   = 8'hd0;
  localparam logic [7:0] CMD_SEL_TAG   = 8'hd8;
  localparam logic [7:0] CMD_ACT_MASK  = 8'he0;
  localparam logic [7:0] CMD_ACTIVATE  = 8'he0;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] wdata;
    logic       bus_bit_seen;
  } req_t;

  typedef struct packed {
    logic       drive_bit;
    logic       drives_bus;
    logic [1:0] card_state;
    logic [2:0] card_tag;
    logic [9:0] io_base;
  } rsp_t;

  typedef struct packed {
    logic [15:0] mac_word0;
    logic [15:0] mac_word1;
    logic [15:0] mac_word2;
    logic [15:0] maker_id_word;
    logic [15:0] address_config_word;
  } eeprom_t;

  // One step of the 8-bit shift generator
  function automatic logic [7:0] seq_next(input logic [7:0] v);
    seq_next = {v[6:0], 1'b0} ^ (v[7] ? SEQ_POLY : 8'h00);
  endfunction

endpackage
`default_nettype wire

[hdl/idpci_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idpci_if
// Valid/ready channels for bus-access requests and card results.
// ----------------------------------------------------------------------------
interface idpci_req_if import idpci_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface idpci_rsp_if import idpci_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/idpci_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idpci_cfg_regs
// EEPROM word registers written through the configuration port.
// ----------------------------------------------------------------------------
module idpci_cfg_regs import idpci_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output eeprom_t                  eeprom_o
);

  eeprom_t eeprom_q, eeprom_d;

  always_comb begin
    eeprom_d = eeprom_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAC0:     eeprom_d.mac_word0           = cfg_data_i;
        CFG_MAC1:     eeprom_d.mac_word1           = cfg_data_i;
        CFG_MAC2:     eeprom_d.mac_word2           = cfg_data_i;
        CFG_MAKER:    eeprom_d.maker_id_word       = cfg_data_i;
        CFG_ADDR_CFG: eeprom_d.address_config_word = cfg_data_i;
        default:      eeprom_d = eeprom_q;  // unused index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eeprom_q <= '0;
    end else begin
      eeprom_q <= eeprom_d;
    end
  end

  assign eeprom_o = eeprom_q;

endmodule
`default_nettype wire

[hdl/idpci_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idpci_core
// Card protocol state and its combinational update for one bus access.
// ----------------------------------------------------------------------------
module idpci_core import idpci_pkg::*; #(
  parameter int unsigned MAKER_OFFSET    = 7,
  parameter int unsigned ADDR_CFG_OFFSET = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic adv_i,     // process req_i this cycle
  input  req_t      req_i,
  input  eeprom_t   eeprom_i,
  output rsp_t      rsp_o      // result from the updated state
);

  phase_e      phase_q, phase_d;
  logic [7:0]  exp_q, exp_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [2:0]  tag_q, tag_d;
  logic [15:0] word_q, word_d;
  logic [4:0]  bits_q, bits_d;
  logic        lost_q, lost_d;
  logic [4:0]  base_q, base_d;

  logic [7:0]  b;
  logic [7:0]  cnt_inc;
  logic [5:0]  off;
  logic [15:0] rom_word;
  logic        dbit;
  logic        drives;

  assign b       = req_i.wdata;
  assign cnt_inc = cnt_q + 8'd1;
  assign off     = b[5:0];
  assign dbit    = word_q[~bits_q[3:0]];  // MSB first

  always_comb begin
    if (off == 6'd0) begin
      rom_word = eeprom_i.mac_word0;
    end else if (off == 6'd1) begin
      rom_word = eeprom_i.mac_word1;
    end else if (off == 6'd2) begin
      rom_word = eeprom_i.mac_word2;
    end else if (off == 6'(MAKER_OFFSET)) begin
      rom_word = eeprom_i.maker_id_word;
    end else if (off == 6'(ADDR_CFG_OFFSET)) begin
      rom_word = eeprom_i.address_config_word;
    end else begin
      rom_word = '0;
    end
  end

  always_comb begin
    phase_d = phase_q;
    exp_d   = exp_q;
    cnt_d   = cnt_q;
    tag_d   = tag_q;
    word_d  = word_q;
    bits_d  = bits_q;
    lost_d  = lost_q;
    base_d  = base_q;
    drives  = 1'b0;

    unique case (func_e'(req_i.func))
      FN_WRITE: begin
        if (phase_q == PH_WAIT) begin
          if (b == exp_q) begin
            cnt_d = cnt_inc;
            exp_d = seq_next(exp_q);
            if (cnt_inc == SEQ_LEN) begin
              phase_d = PH_CMD;
              exp_d   = SEQ_START;
              cnt_d   = '0;
            end
          end else if (b == SEQ_START) begin
            // wrong byte may open a new sequence
            cnt_d = 8'd1;
            exp_d = seq_next(SEQ_START);
          end else begin
            exp_d = SEQ_START;
            cnt_d = '0;
          end
        end else if (phase_q == PH_CMD) begin
          priority if (b == CMD_WAIT) begin
            phase_d = PH_WAIT;
            exp_d   = SEQ_START;
            cnt_d   = '0;
          end else if (b == CMD_GLOBAL_RST) begin
            tag_d   = '0;
            phase_d = PH_WAIT;
            exp_d   = SEQ_START;
            cnt_d   = '0;
          end else if ((b & CMD_LOAD_MASK) == CMD_LOAD) begin
            word_d = rom_word;
            bits_d = '0;
            lost_d = 1'b0;
          end else if ((b & CMD_TAG_MASK) == CMD_SET_TAG) begin
            tag_d = b[2:0];
          end else if ((b & CMD_TAG_MASK) == CMD_SEL_TAG) begin
            if (b[2:0] != tag_q) begin
              phase_d = PH_WAIT;
              exp_d   = SEQ_START;
              cnt_d   = '0;
            end
          end else if ((b & CMD_ACT_MASK) == CMD_ACTIVATE) begin
            base_d  = b[4:0];
            phase_d = PH_ACTIVE;
          end else begin
            phase_d = phase_q;  // unknown command
          end
        end
      end
      FN_READ: begin
        if (phase_q == PH_CMD && !bits_q[4]) begin
          drives = 1'b1;
          lost_d = lost_q | (dbit != req_i.bus_bit_seen);
          bits_d = bits_q + 5'd1;
          if (bits_q[3:0] == 4'hf && lost_d) begin
            phase_d = PH_WAIT;
            exp_d   = SEQ_START;
            cnt_d   = '0;
          end
        end
      end
      FN_RESET: begin
        if (phase_q == PH_ACTIVE) begin
          tag_d   = '0;
          phase_d = PH_WAIT;
          exp_d   = SEQ_START;
          cnt_d   = '0;
        end
      end
      FN_NONE: begin
        phase_d = phase_q;
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      exp_q   <= SEQ_START;
      cnt_q   <= '0;
      tag_q   <= '0;
      word_q  <= '0;
      bits_q  <= '0;
      lost_q  <= 1'b0;
      base_q  <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      exp_q   <= exp_d;
      cnt_q   <= cnt_d;
      tag_q   <= tag_d;
      word_q  <= word_d;
      bits_q  <= bits_d;
      lost_q  <= lost_d;
      base_q  <= base_d;
    end
  end

  always_comb begin
    rsp_o.drive_bit  = drives & dbit;
    rsp_o.drives_bus = drives;
    rsp_o.card_tag   = tag_d;
    rsp_o.io_base    = {1'b1, base_d, 4'h0};  // 0x200 + code * 16
    unique case (phase_d)
      PH_WAIT:   rsp_o.card_state = CS_WAIT;
      PH_CMD:    rsp_o.card_state = CS_CMD;
      PH_ACTIVE: rsp_o.card_state = CS_ACTIVE;
      default:   rsp_o.card_state = CS_WAIT;
    endcase
  end

endmodule
`default_nettype wire

[hdl/id_port_contention_isolator.sv]
`timescale 1ns / 1ps
`default_nettype none
// Path: a request is held in the input register, its result in the result register.
// Throughput: one request per cycle unless rsp_o stalls; the card state update is
//   combinational logic between the input register and the result register.
// Reset: rst_ni async, active low; card goes to waiting, sequence at 0xff,
//   tag, loaded word and base code cleared, EEPROM words cleared.
// ----------------------------------------------------------------------------
// id_port_contention_isolator
// Card-side ID-port isolation: sequence match, command decode, bit contention.
// ----------------------------------------------------------------------------
module id_port_contention_isolator import idpci_pkg::*; #(
  parameter int unsigned MAKER_OFFSET    = 7,
  parameter int unsigned ADDR_CFG_OFFSET = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  idpci_req_if.sink                req_i,
  idpci_rsp_if.source              rsp_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // --------------------------------------------------------------------------
  // Input register: holds one request until the result register can take it.
  // --------------------------------------------------------------------------
  logic    s1_valid_q, s1_valid_d;
  req_t    s1_req_q;
  logic    s1_adv;      // request in s1 is processed this cycle
  logic    in_take;     // request accepted from the channel

  // Result register
  logic    out_valid_q, out_valid_d;
  rsp_t    out_data_q;
  rsp_t    core_rsp;

  eeprom_t eeprom;

  // s1 drains whenever the result register is empty or being emptied
  assign s1_adv     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  // accept a new request whenever s1 is empty or leaving
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign in_take    = req_i.valid && req_i.ready;

  assign s1_valid_d  = in_take || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_req_q <= req_i.data;
    end
    if (s1_adv) begin
      out_data_q <= core_rsp;
    end
  end

  // --------------------------------------------------------------------------
  // EEPROM words and card state
  // --------------------------------------------------------------------------
  idpci_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .eeprom_o   (eeprom)
  );

  idpci_core #(
    .MAKER_OFFSET    (MAKER_OFFSET),
    .ADDR_CFG_OFFSET (ADDR_CFG_OFFSET)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (s1_adv),
    .req_i    (s1_req_q),
    .eeprom_i (eeprom),
    .rsp_o    (core_rsp)
  );

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("accepted request not held in input register");

  a_adv_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> rsp_o.valid)
    else $error("processed request produced no result");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !rsp_o.ready) |-> !req_i.ready)
    else $error("request accepted while both stages are full");

  a_drive_only_answering: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.data.drive_bit) |-> rsp_o.data.drives_bus)
    else $error("bus bit driven on a read the card does not answer");

endmodule
`default_nettype wire
